[rtl/q2e_pkg.sv]
// Package: shared widths, constants and the CORDIC angle table
`default_nettype none
package q2e_pkg;
	localparam int QW        = 16;
	localparam int CfgW      = 15;
	localparam int RollW     = 16;
	localparam int PitchW    = 15;
	localparam int YawW      = 17;
	localparam int StepsDef  = 16;
	localparam int TabLen    = 24;
	// CORDIC datapath width: operands up to 2^34 * 256, plus growth
	localparam int DW        = 48;
	localparam int AW        = 34;
	localparam logic signed [AW-1:0] QuarterTurn = 34'sd754974720;
	localparam int AngleLimit = 23040;
	localparam logic signed [33:0] SingLimit = 34'sd535822336;

	typedef struct packed {
		logic               lock;
		logic signed [1:0]  sgn;
	} q2e_tag_t;

	function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
		logic signed [AW-1:0] r;
		begin
			unique case (i)
				5'd0:  r = 34'sd377487360;
				5'd1:  r = 34'sd222843801;
				5'd2:  r = 34'sd117744544;
				5'd3:  r = 34'sd59768969;
				5'd4:  r = 34'sd30000467;
				5'd5:  r = 34'sd15014858;
				5'd6:  r = 34'sd7509261;
				5'd7:  r = 34'sd3754860;
				5'd8:  r = 34'sd1877459;
				5'd9:  r = 34'sd938733;
				5'd10: r = 34'sd469367;
				5'd11: r = 34'sd234683;
				5'd12: r = 34'sd117342;
				5'd13: r = 34'sd58671;
				5'd14: r = 34'sd29335;
				5'd15: r = 34'sd14668;
				5'd16: r = 34'sd7334;
				5'd17: r = 34'sd3667;
				5'd18: r = 34'sd1833;
				5'd19: r = 34'sd917;
				5'd20: r = 34'sd458;
				5'd21: r = 34'sd229;
				5'd22: r = 34'sd115;
				5'd23: r = 34'sd57;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

[rtl/q2e_if.sv]
// Interfaces: quaternion request channel and Euler result channel
`default_nettype none
interface q2e_in_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  quat_x;
	logic signed [15:0]  quat_y;
	logic signed [15:0]  quat_z;
	logic signed [15:0]  quat_w;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_out_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  roll_angle;
	logic signed [14:0]  pitch_angle;
	logic signed [16:0]  yaw_angle;
	logic                gimbal_lock;
	logic                attitude_level;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		attitude_level, input ready);
	modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		attitude_level, output ready);
endinterface
`default_nettype wire

[rtl/q2e_isqrt_cell.sv]
// Module: one radix-4 step of the integer square root chain
`default_nettype none
module q2e_isqrt_cell #(
	parameter int Step = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [60:0] n_in,
	input  wire logic [60:0] r_in,
	output logic      [60:0] n_out,
	output logic      [60:0] r_out
);
	localparam logic [60:0] Bit = 61'd1 << (60 - 2*Step);
	logic [61:0] trial;

	// Compare remainder against root plus current bit
	always_comb begin
		trial = {1'b0, r_in} + {1'b0, Bit};
	end

	// Advance one digit
	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, n_in} >= trial) begin
				n_out <= n_in - trial[60:0];
				r_out <= (r_in >> 1) + Bit;
			end else begin
				n_out <= n_in;
				r_out <= r_in >> 1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/q2e_cordic_cell.sv]
// Module: one vectoring CORDIC micro-rotation for three lanes
`default_nettype none
module q2e_cordic_cell #(
	parameter int Step = 0
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [3*q2e_pkg::DW-1:0] x_in,
	input  wire logic signed [3*q2e_pkg::DW-1:0] y_in,
	input  wire logic signed [3*q2e_pkg::AW-1:0] a_in,
	output logic      signed [3*q2e_pkg::DW-1:0] x_out,
	output logic      signed [3*q2e_pkg::DW-1:0] y_out,
	output logic      signed [3*q2e_pkg::AW-1:0] a_out
);
	import q2e_pkg::*;
	localparam logic [4:0] Idx = 5'(Step);
	localparam logic signed [AW-1:0] Ang = atan_tab(Idx);

	// Rotate each lane toward the x axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0] xv, yv;
				logic signed [AW-1:0] av;
				xv = x_in[k*DW +: DW];
				yv = y_in[k*DW +: DW];
				av = a_in[k*AW +: AW];
				if (!yv[DW-1]) begin
					x_out[k*DW +: DW] <= xv + (yv >>> Step);
					y_out[k*DW +: DW] <= yv - (xv >>> Step);
					a_out[k*AW +: AW] <= av + Ang;
				end else begin
					x_out[k*DW +: DW] <= xv - (yv >>> Step);
					y_out[k*DW +: DW] <= yv + (xv >>> Step);
					a_out[k*AW +: AW] <= av - Ang;
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/quaternion_to_euler_angles_top.sv]
// Top level: quaternion to ZYX Euler angles, fully pipelined
// Usage:
//   in  : quaternion request (quat_x/y/z/w, signed Q1.15), valid/ready.
//   out : roll, pitch, yaw in 1/128 degree plus gimbal_lock and
//         attitude_level flags, valid/ready.
//   cfg_we/cfg_wdata writes the 15-bit tilt limit (reset 128).
// Throughput: one request per cycle while the receiver does not stall. Pipeline:
// products, sums, square of s, 31 square root cells for the pitch cosine,
// quadrant prerotation, one CORDIC cell per step (min(CORDIC_STEPS, 24)),
// rounding into the output register.
// Every stage advances together; when the receiver stalls with a result
// in the output register, the whole pipeline holds and in.ready drops.
// Reset clears all valid bits and loads the tilt limit; no clearing pass.
`default_nettype none
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = q2e_pkg::StepsDef
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	q2e_in_if.sink                          in,
	q2e_out_if.source                       out,
	input  wire logic                       cfg_we,
	input  wire logic [q2e_pkg::CfgW-1:0]   cfg_wdata
);
	import q2e_pkg::*;
	localparam int NS = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
	localparam int SQ = 31;
	localparam int LAT = 3 + SQ + 1 + NS + 1;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [CfgW-1:0] tilt_q;

	// Pipeline advances unless the output holds an unread result
	assign en = !(out.valid && !out.ready);
	assign in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			tilt_q <= CfgW'(128);
		end else begin
			if (cfg_we) tilt_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[LAT-2:0], in.valid};
		end
	end

	// Stage 1: register products
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, wy_s1, xz_s1, yz_s1, wx_s1, xy_s1, wz_s1;
	logic signed [15:0] qx_s1, qw_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= 32'(in.quat_w) * 32'(in.quat_w);
			xx_s1 <= 32'(in.quat_x) * 32'(in.quat_x);
			yy_s1 <= 32'(in.quat_y) * 32'(in.quat_y);
			zz_s1 <= 32'(in.quat_z) * 32'(in.quat_z);
			wy_s1 <= 32'(in.quat_w) * 32'(in.quat_y);
			xz_s1 <= 32'(in.quat_x) * 32'(in.quat_z);
			yz_s1 <= 32'(in.quat_y) * 32'(in.quat_z);
			wx_s1 <= 32'(in.quat_w) * 32'(in.quat_x);
			xy_s1 <= 32'(in.quat_x) * 32'(in.quat_y);
			wz_s1 <= 32'(in.quat_w) * 32'(in.quat_z);
			qx_s1 <= in.quat_x;
			qw_s1 <= in.quat_w;
		end
	end

	// Stage 2: sums and singular test
	logic signed [34:0] ry_s2, rx_s2, yy2_s2, yx_s2, s_s2;
	q2e_tag_t tag_s2;
	logic signed [15:0] qx_s2, qw_s2;
	always_ff @(posedge clk) begin
		logic signed [33:0] t;
		if (en) begin
			t = 34'(wy_s1) - 34'(xz_s1);
			ry_s2  <= 35'(2) * (35'(yz_s1) + 35'(wx_s1));
			rx_s2  <= 35'(ww_s1) - 35'(xx_s1) - 35'(yy_s1) + 35'(zz_s1);
			yy2_s2 <= 35'(2) * (35'(xy_s1) + 35'(wz_s1));
			yx_s2  <= 35'(ww_s1) + 35'(xx_s1) - 35'(yy_s1) - 35'(zz_s1);
			s_s2   <= 35'(t) * 35'(2);
			tag_s2.lock <= (t > SingLimit) || (t < -SingLimit);
			tag_s2.sgn  <= (t > 0) ? 2'sd1 : -2'sd1;
			qx_s2 <= qx_s1;
			qw_s2 <= qw_s1;
		end
	end

	// Stage 3: radicand 2^60 - s*s for the pitch cosine
	logic [60:0] sq_s3;
	logic signed [34:0] ry_s3, rx_s3, yy2_s3, yx_s3, s_s3;
	q2e_tag_t tag_s3;
	logic signed [15:0] qx_s3, qw_s3;
	always_ff @(posedge clk) begin
		logic [31:0] sa;
		if (en) begin
			sa = s_s2[34] ? 32'(-s_s2) : 32'(s_s2);
			sq_s3  <= (61'd1 << 60) - 61'(64'(sa) * 64'(sa));
			ry_s3 <= ry_s2; rx_s3 <= rx_s2; yy2_s3 <= yy2_s2; yx_s3 <= yx_s2;
			s_s3 <= s_s2; tag_s3 <= tag_s2; qx_s3 <= qx_s2; qw_s3 <= qw_s2;
		end
	end

	// Square root chain, with side data delayed alongside
	logic [60:0] sn [SQ+1];
	logic [60:0] sr [SQ+1];
	assign sn[0] = sq_s3;
	assign sr[0] = '0;
	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		q2e_isqrt_cell #(.Step(g)) u_cell (
			.clk(clk), .en(en), .n_in(sn[g]), .r_in(sr[g]),
			.n_out(sn[g+1]), .r_out(sr[g+1])
		);
	end
	logic signed [34:0] ry_d [SQ+1], rx_d [SQ+1], yy2_d [SQ+1], yx_d [SQ+1], s_d [SQ+1];
	q2e_tag_t tag_d [SQ+1];
	logic signed [15:0] qx_d [SQ+1], qw_d [SQ+1];
	assign ry_d[0] = ry_s3; assign rx_d[0] = rx_s3; assign yy2_d[0] = yy2_s3;
	assign yx_d[0] = yx_s3; assign s_d[0] = s_s3; assign tag_d[0] = tag_s3;
	assign qx_d[0] = qx_s3; assign qw_d[0] = qw_s3;
	for (genvar g = 0; g < SQ; g++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				ry_d[g+1] <= ry_d[g]; rx_d[g+1] <= rx_d[g];
				yy2_d[g+1] <= yy2_d[g]; yx_d[g+1] <= yx_d[g];
				s_d[g+1] <= s_d[g]; tag_d[g+1] <= tag_d[g];
				qx_d[g+1] <= qx_d[g]; qw_d[g+1] <= qw_d[g];
			end
		end
	end

	// CORDIC prerotation: lanes roll, pitch, yaw (yaw lane uses x,w when locked)
	logic signed [3*DW-1:0] cx [NS+1];
	logic signed [3*DW-1:0] cy [NS+1];
	logic signed [3*AW-1:0] ca [NS+1];
	logic [2:0] zero_p;
	q2e_tag_t tag_p;
	always_ff @(posedge clk) begin
		logic signed [DW-1:0] yv [3];
		logic signed [DW-1:0] xv [3];
		q2e_tag_t tg;
		if (en) begin
			tg = tag_d[SQ];
			yv[0] = DW'(ry_d[SQ]);  xv[0] = DW'(rx_d[SQ]);
			yv[1] = DW'(s_d[SQ]);   xv[1] = DW'({1'b0, sr[SQ]});
			if (tg.lock) begin
				yv[2] = DW'(qx_d[SQ]); xv[2] = DW'(qw_d[SQ]);
			end else begin
				yv[2] = DW'(yy2_d[SQ]); xv[2] = DW'(yx_d[SQ]);
			end
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0] xs, ys;
				xs = xv[k] <<< 8;
				ys = yv[k] <<< 8;
				zero_p[k] <= (xv[k] == '0) && (yv[k] == '0);
				if (xs[DW-1]) begin
					if (!ys[DW-1]) begin
						cx[0][k*DW +: DW] <= ys; cy[0][k*DW +: DW] <= -xs;
						ca[0][k*AW +: AW] <= QuarterTurn;
					end else begin
						cx[0][k*DW +: DW] <= -ys; cy[0][k*DW +: DW] <= xs;
						ca[0][k*AW +: AW] <= -QuarterTurn;
					end
				end else begin
					cx[0][k*DW +: DW] <= xs; cy[0][k*DW +: DW] <= ys;
					ca[0][k*AW +: AW] <= '0;
				end
			end
			tag_p <= tg;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_cordic
		q2e_cordic_cell #(.Step(g)) u_cell (
			.clk(clk), .en(en), .x_in(cx[g]), .y_in(cy[g]), .a_in(ca[g]),
			.x_out(cx[g+1]), .y_out(cy[g+1]), .a_out(ca[g+1])
		);
	end
	logic [2:0] zero_d [NS+1];
	q2e_tag_t tag_c [NS+1];
	assign zero_d[0] = zero_p;
	assign tag_c[0] = tag_p;
	for (genvar g = 0; g < NS; g++) begin : g_cdly
		always_ff @(posedge clk) begin
			if (en) begin
				zero_d[g+1] <= zero_d[g];
				tag_c[g+1] <= tag_c[g];
			end
		end
	end

	// Round, saturate, select branch and compare against the tilt limit
	logic signed [17:0] ang [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [AW-1:0] r;
			r = ($signed(ca[NS][k*AW +: AW]) + AW'(32768)) >>> 16;
			if (zero_d[NS][k])              ang[k] = '0;
			else if (r > AngleLimit)        ang[k] = 18'sd23040;
			else if (r < -AngleLimit)       ang[k] = -18'sd23040;
			else                            ang[k] = 18'(r);
		end
	end

	always_ff @(posedge clk) begin
		logic signed [17:0] rl, pt, yw;
		logic [17:0] ar, ap;
		q2e_tag_t tg;
		if (en) begin
			tg = tag_c[NS];
			if (tg.lock) begin
				rl = '0;
				pt = (tg.sgn > 0) ? 18'sd11520 : -18'sd11520;
				yw = (tg.sgn > 0) ? -(ang[2] <<< 1) : (ang[2] <<< 1);
			end else begin
				rl = ang[0]; pt = ang[1]; yw = ang[2];
			end
			ar = rl[17] ? 18'(-rl) : 18'(rl);
			ap = pt[17] ? 18'(-pt) : 18'(pt);
			out.roll_angle     <= 16'(rl);
			out.pitch_angle    <= 15'(pt);
			out.yaw_angle      <= 17'(yw);
			out.gimbal_lock    <= tg.lock;
			out.attitude_level <= (ar < 18'(tilt_q)) && (ap < 18'(tilt_q));
		end
	end
	assign out.valid = vld_q[LAT-1];

	// Checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.roll_angle))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready == !(out.valid && !out.ready))
		else $error("ready mismatch");
	a_lock_roll: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.gimbal_lock |-> out.roll_angle == 16'sd0)
		else $error("roll not zero in gimbal lock");
endmodule
`default_nettype wire
